FILE: hw/rtl/avt_pkg.sv
// ---------------------------------------------------------------------------
// avt_pkg
// Shared types and constants for the affine vertex transform.
// ---------------------------------------------------------------------------
package avt_pkg;

    localparam int NUM_COEF  = 12;
    localparam int IDX_W     = 4;
    localparam int FIELD_W   = 32;

    // Slot layout of the column-major matrix.
    localparam int COL0_BASE  = 0;
    localparam int COL1_BASE  = 3;
    localparam int COL2_BASE  = 6;
    localparam int TRANS_BASE = 9;
    localparam int NUM_AXES   = 3;

    // Input word layout, lowest bit first.
    localparam int S_IDX_LSB  = 0;
    localparam int S_VAL_LSB  = S_IDX_LSB + IDX_W;
    localparam int S_X_LSB    = S_VAL_LSB + FIELD_W;
    localparam int S_Y_LSB    = S_X_LSB + FIELD_W;
    localparam int S_Z_LSB    = S_Y_LSB + FIELD_W;
    localparam int S_USED_W   = S_Z_LSB + FIELD_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Output word layout.
    localparam int M_TDATA_W  = NUM_AXES * FIELD_W;

    // Operation codes carried in s_tuser.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } coef_wr_t;

endpackage

FILE: hw/rtl/avt_coef_bank.sv
// ---------------------------------------------------------------------------
// avt_coef_bank
// Twelve-entry coefficient register file, identity matrix after reset.
// ---------------------------------------------------------------------------
module avt_coef_bank #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  avt_pkg::coef_wr_t                             wr,
    input  logic [VALUE_WIDTH-1:0]                        wr_data,
    output logic [avt_pkg::NUM_COEF-1:0][VALUE_WIDTH-1:0] coef
);

    localparam logic [VALUE_WIDTH-1:0] COEF_ONE = VALUE_WIDTH'(64'(1) << FRAC_BITS);

    logic [avt_pkg::NUM_COEF-1:0][VALUE_WIDTH-1:0] coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // diagonal slots get one, everything else zero
            for (int i = 0; i < avt_pkg::NUM_COEF; i++) begin
                if ((i == avt_pkg::COL0_BASE) || (i == avt_pkg::COL1_BASE + 1)
                        || (i == avt_pkg::COL2_BASE + 2)) begin
                    coef_reg[i] <= COEF_ONE;
                end else begin
                    coef_reg[i] <= '0;
                end
            end
        end else begin
            // slots 12..15 match nothing and are dropped
            for (int i = 0; i < avt_pkg::NUM_COEF; i++) begin
                if (wr.en && (wr.idx == avt_pkg::IDX_W'(i))) begin
                    coef_reg[i] <= wr_data;
                end
            end
        end
    end

    assign coef = coef_reg;

endmodule

FILE: hw/rtl/avt_lane.sv
// ---------------------------------------------------------------------------
// avt_lane
// One output axis: x*cx + y*cy + z*cz, floor shift, add translation,
// saturate. Four register stages, all advanced by en.
// ---------------------------------------------------------------------------
module avt_lane #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [VALUE_WIDTH-1:0]     x,
    input  logic signed [VALUE_WIDTH-1:0]     y,
    input  logic signed [VALUE_WIDTH-1:0]     z,
    input  logic        [VALUE_WIDTH-1:0]     cx,
    input  logic        [VALUE_WIDTH-1:0]     cy,
    input  logic        [VALUE_WIDTH-1:0]     cz,
    input  logic        [VALUE_WIDTH-1:0]     ct,
    output logic        [avt_pkg::FIELD_W-1:0] result,
    output logic                              sat
);

    localparam int VW    = VALUE_WIDTH;
    localparam int LO_W  = VW / 2;
    localparam int HI_W  = VW - LO_W;
    localparam int PL_W  = VW + LO_W + 1;
    localparam int PH_W  = VW + HI_W;
    localparam int PR_W  = 2 * VW;
    localparam int SUM_W = PR_W + 2;
    localparam int SH_W  = SUM_W - FRAC_BITS;
    localparam int TOT_W = ((SH_W > VW) ? SH_W : VW) + 1;
    localparam int FW    = avt_pkg::FIELD_W;

    logic signed [VW-1:0] ops [3];
    logic        [VW-1:0] cfs [3];

    assign ops[0] = x;
    assign ops[1] = y;
    assign ops[2] = z;
    assign cfs[0] = cx;
    assign cfs[1] = cy;
    assign cfs[2] = cz;

    // stage 1: split multiply (coef low half unsigned, high half signed)
    logic signed [PL_W-1:0] pl_next [3];
    logic signed [PH_W-1:0] ph_next [3];
    logic signed [PL_W-1:0] pl_reg  [3];
    logic signed [PH_W-1:0] ph_reg  [3];
    logic        [VW-1:0]   t1_reg;

    for (genvar k = 0; k < 3; k++) begin : g_mul
        assign pl_next[k] = ops[k] * $signed({1'b0, cfs[k][LO_W-1:0]});
        assign ph_next[k] = ops[k] * $signed(cfs[k][VW-1:LO_W]);
    end

    // stage 2: recombine partial products
    logic signed [PR_W-1:0] pr_next [3];
    logic signed [PR_W-1:0] pr_reg  [3];
    logic        [VW-1:0]   t2_reg;

    for (genvar k = 0; k < 3; k++) begin : g_comb
        assign pr_next[k] = $signed({ph_reg[k], {LO_W{1'b0}}})
                          + $signed({{(PR_W - PL_W){pl_reg[k][PL_W-1]}}, pl_reg[k]});
    end

    // stage 3: exact three-term sum, floored at the fraction boundary
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SH_W-1:0]  sh_reg;
    logic        [VW-1:0]    t3_reg;

    assign sum_next = $signed({{2{pr_reg[0][PR_W-1]}}, pr_reg[0]})
                    + $signed({{2{pr_reg[1][PR_W-1]}}, pr_reg[1]})
                    + $signed({{2{pr_reg[2][PR_W-1]}}, pr_reg[2]});

    // stage 4: translation and saturation to the value range
    logic signed [TOT_W-1:0] tot;
    logic                    fits;
    logic        [VW-1:0]    clip_next;
    logic        [VW-1:0]    clip_reg;
    logic                    sat_reg;

    assign tot = $signed({{(TOT_W - SH_W){sh_reg[SH_W-1]}}, sh_reg})
               + $signed({{(TOT_W - VW){t3_reg[VW-1]}}, t3_reg});
    assign fits = (&tot[TOT_W-1:VW-1]) || !(|tot[TOT_W-1:VW-1]);

    always_comb begin
        if (fits) begin
            clip_next = tot[VW-1:0];
        end else if (tot[TOT_W-1]) begin
            clip_next = {1'b1, {(VW-1){1'b0}}};
        end else begin
            clip_next = {1'b0, {(VW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pl_reg[k] <= pl_next[k];
                ph_reg[k] <= ph_next[k];
                pr_reg[k] <= pr_next[k];
            end
            t1_reg   <= ct;
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            sh_reg   <= sum_next[SUM_W-1:FRAC_BITS];
            clip_reg <= clip_next;
            sat_reg  <= !fits;
        end
    end

    // field is sign-extended or truncated to 32 bits
    if (VW >= FW) begin : g_trunc
        assign result = clip_reg[FW-1:0];
    end else begin : g_sext
        assign result = {{(FW - VW){clip_reg[VW-1]}}, clip_reg};
    end

    assign sat = sat_reg;

endmodule

FILE: hw/rtl/affine_vertex_transform_top.sv
// ---------------------------------------------------------------------------
// affine_vertex_transform_top
// Streaming 3D affine point transform with a loadable column-major matrix.
// ---------------------------------------------------------------------------
// The block takes one word per clock while the output is not stalled and
// returns each transformed point from its last register stage. A word with
// s_tuser = 0 loads one coefficient (slot in coef_index, value in coef_value)
// and produces no output; loads to slots 12..15 are dropped. A word with
// s_tuser = 1 carries a point and yields out = floor(M*p / 2^FRAC_BITS) + t
// per axis, saturated to the signed VALUE_WIDTH range, with m_tuser set when
// any axis clipped. The datapath has four stages: split multiply,
// partial-product merge, three-term sum with floor shift, and translation
// add with saturation. A load takes effect for the very next point word.
// The whole pipeline stalls together only while m_tvalid is held high with
// m_tready low; otherwise s_tready is high every cycle. After reset the
// matrix is the identity with zero translation.
// ---------------------------------------------------------------------------
module affine_vertex_transform_top #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, low bit up: coef_index[3:0], coef_value[31:0], in_x[31:0],
    // in_y[31:0], in_z[31:0], zero pad[3:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [avt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,   // mode
    // m_tdata, low bit up: out_x[31:0], out_y[31:0], out_z[31:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [avt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser    // saturated
);

    localparam int VW = VALUE_WIDTH;
    localparam int FW = avt_pkg::FIELD_W;

    // ---- handshake: the pipeline moves whenever the output slot frees up
    logic en;
    logic s_acc;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign s_acc    = s_tvalid && en;

    // ---- unpack the input word
    logic [avt_pkg::IDX_W-1:0] coef_index;
    logic [FW-1:0]             coef_value;
    logic [FW-1:0]             in_x;
    logic [FW-1:0]             in_y;
    logic [FW-1:0]             in_z;

    assign coef_index = s_tdata[avt_pkg::S_IDX_LSB +: avt_pkg::IDX_W];
    assign coef_value = s_tdata[avt_pkg::S_VAL_LSB +: FW];
    assign in_x       = s_tdata[avt_pkg::S_X_LSB   +: FW];
    assign in_y       = s_tdata[avt_pkg::S_Y_LSB   +: FW];
    assign in_z       = s_tdata[avt_pkg::S_Z_LSB   +: FW];

    // Value fields read as signed VW-bit numbers from their low bits; a
    // 32-bit field in a wider datapath is zero-extended.
    logic [VW-1:0] val_c;
    logic [VW-1:0] val_x;
    logic [VW-1:0] val_y;
    logic [VW-1:0] val_z;

    if (VW <= FW) begin : g_narrow
        assign val_c = coef_value[VW-1:0];
        assign val_x = in_x[VW-1:0];
        assign val_y = in_y[VW-1:0];
        assign val_z = in_z[VW-1:0];
    end else begin : g_wide
        assign val_c = {{(VW - FW){1'b0}}, coef_value};
        assign val_x = {{(VW - FW){1'b0}}, in_x};
        assign val_y = {{(VW - FW){1'b0}}, in_y};
        assign val_z = {{(VW - FW){1'b0}}, in_z};
    end

    // ---- coefficient store; written as the load word is accepted
    avt_pkg::coef_wr_t                     coef_wr;
    logic [avt_pkg::NUM_COEF-1:0][VW-1:0]  coef;

    assign coef_wr.en  = s_acc && (s_tuser == avt_pkg::MODE_LOAD);
    assign coef_wr.idx = coef_index;

    avt_coef_bank #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_coef_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (coef_wr),
        .wr_data (val_c),
        .coef    (coef)
    );

    // ---- valid bits travel with the data through the four stages
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic vo_reg;
    logic v1_next;

    assign v1_next = s_acc && (s_tuser == avt_pkg::MODE_XFORM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // ---- one lane per output axis, reading its matrix row from the store
    logic [avt_pkg::NUM_AXES-1:0] lane_sat;

    for (genvar k = 0; k < avt_pkg::NUM_AXES; k++) begin : g_lane
        avt_lane #(
            .FRAC_BITS   (FRAC_BITS),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_lane (
            .aclk   (aclk),
            .en     (en),
            .x      (val_x),
            .y      (val_y),
            .z      (val_z),
            .cx     (coef[avt_pkg::COL0_BASE + k]),
            .cy     (coef[avt_pkg::COL1_BASE + k]),
            .cz     (coef[avt_pkg::COL2_BASE + k]),
            .ct     (coef[avt_pkg::TRANS_BASE + k]),
            .result (m_tdata[k*FW +: FW]),
            .sat    (lane_sat[k])
        );
    end

    assign m_tvalid = vo_reg;
    assign m_tuser  = |lane_sat;

endmodule

FILE: hw/rtl/avt_checker.sv
// ---------------------------------------------------------------------------
// avt_checker
// Port-level checks on the affine vertex transform, bound to the top level.
// ---------------------------------------------------------------------------
module avt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [avt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // input is blocked only by a stalled output word
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output slot");

    // an accepted point word reaches m_tvalid when the sink keeps up
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == avt_pkg::MODE_XFORM))
            ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("point word lost in pipeline");

    // nothing is presented right after a reset edge
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

endmodule

bind affine_vertex_transform_top avt_checker u_avt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
